### rtl/core/base128_septet_codec_unit_assert.svh
// ----------------------------------------------------------------------------
// base128_septet_codec_unit_assert.svh
// Assertion macros shared by the septet codec RTL. They expand to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BASE128_SEPTET_CODEC_UNIT_ASSERT_SVH
`define BASE128_SEPTET_CODEC_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define B128SC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("b128sc assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define B128SC_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("b128sc assertion failed");
`else
`define B128SC_ASSERT_IMP(label, clk, rst, pre, post)
`define B128SC_ASSERT_NXT(label, clk, rst, pre, post)
`endif

`endif

### rtl/core/b128sc_pkg.sv
// ----------------------------------------------------------------------------
// b128sc_pkg
// Types and constants of the base-128 septet codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b128sc_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned ACC_W  = 15;
   localparam int unsigned POS_W  = 3;
   localparam int unsigned CNT_W  = 2;

   localparam logic [7:0] SEPT_MASK = 8'h7f;
   localparam logic [7:0] SEPT_FLAG = 8'h80;

   // Last position of a seven-byte encode group.
   localparam logic [POS_W-1:0] ENC_LAST_POS = 3'd6;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Register word index (paddr[2]).
   localparam logic REG_DIRECTION = 1'b0;

   typedef struct packed {
      logic             run_last;
      logic             message_end;
      logic             byte_valid;
      logic [DATA_W-1:0] out_byte;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      result_type       res1;
      result_type       res0;
   } push_type;

   typedef struct packed {
      logic direction;
      logic clear;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/core/b128sc_csr.sv
// ----------------------------------------------------------------------------
// b128sc_csr
// Register slave for the codec: holds the direction bit and pulses a state
// clear whenever it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b128sc_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic      [31:0]        csr_prdata,
   output logic                    csr_pready,
   output b128sc_pkg::cfg_type     cfg
);

   logic direction_ff;
   logic direction_in;
   logic wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == b128sc_pkg::REG_DIRECTION);

   assign direction_in = wr_hit ? csr_pwdata[0] : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= b128sc_pkg::DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   // Unused data bits and the byte offset are ignored on reads.
   assign csr_prdata = (csr_paddr[2] == b128sc_pkg::REG_DIRECTION)
                       ? {31'd0, direction_ff} : 32'd0;

   assign cfg.direction = direction_ff;
   assign cfg.clear     = wr_hit;

endmodule

`default_nettype wire

### rtl/core/b128sc_engine.sv
// ----------------------------------------------------------------------------
// b128sc_engine
// Input register, repacking state and the single-pass repack logic. Each
// staged request yields zero, one or two results for the output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base128_septet_codec_unit_assert.svh"

module b128sc_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 req_tlast,
   input  wire logic                 room,
   input  wire b128sc_pkg::cfg_type  cfg,
   output b128sc_pkg::push_type      push
);

   localparam int unsigned ACC_W = b128sc_pkg::ACC_W;
   localparam int unsigned POS_W = b128sc_pkg::POS_W;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         data_ff;
   logic               end_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               advance;
   logic               accept;

   b128sc_pkg::result_type res0, res1;
   logic [1:0]             n_res;
   logic [ACC_W-1:0]       acc_next;
   logic [POS_W-1:0]       pos_next;

   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
         end_ff  <= req_tlast;
      end
   end

   always_comb begin
      logic [POS_W-1:0] p;
      logic [ACC_W-1:0] base;
      logic [ACC_W-1:0] wide;
      logic [ACC_W-1:0] keep;
      logic [3:0]       shamt;
      logic [POS_W-1:0] have;
      logic [POS_W-1:0] hm1;
      logic [ACC_W-1:0] shifted;

      p       = pos_ff;
      base    = acc_ff;
      wide    = '0;
      keep    = '0;
      shamt   = '0;
      have    = '0;
      hm1     = '0;
      shifted = '0;
      res0    = '0;
      res1    = '0;
      n_res   = 2'd0;
      acc_next = '0;
      pos_next = '0;

      if (cfg.direction == b128sc_pkg::DIR_ENCODE) begin
         // A position past the group end restarts with an empty accumulator.
         if (p > b128sc_pkg::ENC_LAST_POS) begin
            p    = '0;
            base = '0;
         end
         wide    = {base[6:0], data_ff};
         shamt   = {1'b0, p} + 4'd1;
         shifted = wide >> shamt;
         res0.out_byte   = {1'b0, shifted[6:0]} | b128sc_pkg::SEPT_FLAG;
         res0.byte_valid = 1'b1;
         n_res = 2'd1;
         keep  = wide & ((15'd1 << shamt) - 15'd1);
         if (p == b128sc_pkg::ENC_LAST_POS) begin
            res1.out_byte   = {1'b0, keep[6:0]} | b128sc_pkg::SEPT_FLAG;
            res1.byte_valid = 1'b1;
            n_res    = 2'd2;
            acc_next = '0;
            pos_next = '0;
         end else begin
            acc_next = keep;
            pos_next = p + 3'd1;
         end
         // Flush the leftover bits, zero padded on the low side.
         if (end_ff && (pos_next != '0)) begin
            shifted = acc_next << (3'd7 - pos_next);
            res1.out_byte   = {1'b0, shifted[6:0]} | b128sc_pkg::SEPT_FLAG;
            res1.byte_valid = 1'b1;
            n_res = 2'd2;
         end
      end else begin
         have = 3'd0 - p;
         hm1  = have - 3'd1;
         wide = {base[7:0], data_ff[6:0]};
         if (have != '0) begin
            shifted = wide >> hm1;
            res0.out_byte   = shifted[7:0];
            res0.byte_valid = 1'b1;
            n_res    = 2'd1;
            acc_next = wide & ((15'd1 << hm1) - 15'd1);
         end else begin
            acc_next = wide;
         end
         pos_next = p + 3'd1;
         // A message end that completes no byte still needs an end marker.
         if (end_ff && (n_res == 2'd0)) begin
            n_res = 2'd1;
         end
      end

      if (n_res == 2'd2) begin
         res1.run_last    = 1'b1;
         res1.message_end = end_ff;
      end else begin
         res0.run_last    = 1'b1;
         res0.message_end = end_ff;
      end

      if (end_ff) begin
         acc_next = '0;
         pos_next = '0;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      pos_in = pos_ff;
      if (cfg.clear) begin
         acc_in = '0;
         pos_in = '0;
      end else if (advance) begin
         acc_in = acc_next;
         pos_in = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pos_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         pos_ff <= pos_in;
      end
   end

   assign push.count = advance ? n_res : 2'd0;
   assign push.res0  = res0;
   assign push.res1  = res1;

   `B128SC_ASSERT_NXT(a_end_clears_state, clock, reset, advance && end_ff,
      (acc_ff == '0) && (pos_ff == '0))
   `B128SC_ASSERT_IMP(a_encode_pos_range, clock, reset,
      cfg.direction == b128sc_pkg::DIR_ENCODE, pos_ff <= b128sc_pkg::ENC_LAST_POS)
   `B128SC_ASSERT_IMP(a_pair_last_flag, clock, reset, push.count == 2'd2,
      push.res1.run_last && !push.res0.run_last && !push.res0.message_end)

endmodule

`default_nettype wire

### rtl/core/b128sc_out_queue.sv
// ----------------------------------------------------------------------------
// b128sc_out_queue
// Three-entry result queue in front of the response channel. The head entry
// drives the channel; room is a function of the registered fill level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "base128_septet_codec_unit_assert.svh"

module b128sc_out_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b128sc_pkg::push_type  push,
   output logic                       room,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output b128sc_pkg::result_type     head
);

   localparam int unsigned DEPTH = 3;
   localparam int unsigned CNT_W = b128sc_pkg::CNT_W;

   b128sc_pkg::result_type q_ff [DEPTH];
   b128sc_pkg::result_type q_in [DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   pop;
   logic [CNT_W-1:0]       base;

   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign room       = (count_ff <= 2'd1);
   assign head       = q_ff[0];
   assign base       = count_ff - {1'b0, pop};
   assign count_in   = base + push.count;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      // A pop moves every entry one place toward the head.
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if ((push.count != 2'd0) && (CNT_W'(i) == base)) begin
            q_in[i] = push.res0;
         end
         if ((push.count == 2'd2) && (CNT_W'(i) == base + 2'd1)) begin
            q_in[i] = push.res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `B128SC_ASSERT_IMP(a_push_has_room, clock, reset, push.count != 2'd0,
      count_ff <= 2'd1)
   `B128SC_ASSERT_IMP(a_end_is_run_last, clock, reset,
      rsp_tvalid && head.message_end, head.run_last)

endmodule

`default_nettype wire

### rtl/core/base128_septet_codec_unit.sv
// ----------------------------------------------------------------------------
// base128_septet_codec_unit
// Streaming 7-to-8 bit repacker: encodes bytes into flagged septets or
// decodes septets back into bytes, selected by the direction register.
// ----------------------------------------------------------------------------
// Path: an accepted request waits in the input register until the result queue
// has room; its results then enter the queue, whose head drives the response.
// Throughput: one request per cycle while the result queue has room; a request
// with two results (the seventh byte of an encode group, or an encode flush at
// message end) holds back further requests, as responses leave one at a time.
// Reset: synchronous, active high; direction returns to encode, the packing
// state and all queued results are cleared.
`timescale 1ns / 1ps
`default_nettype none

module base128_septet_codec_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_in
   input  wire logic        req_tlast,   // message_end_in
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]       rsp_tuser,   // [0] byte_valid, [1] run_last
   output logic             rsp_tlast,   // message_end
   // Register port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // A direction write also clears the packing state, so a message that was
   // in progress is dropped. Writes are only expected while the codec is idle.
   b128sc_pkg::cfg_type    cfg;
   b128sc_pkg::push_type   push;
   b128sc_pkg::result_type head;
   logic                   room;

   b128sc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The engine stages each request in its input register and, in the cycle
   // the queue has room, repacks it against the current state in one pass.
   b128sc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .room       (room),
      .cfg        (cfg),
      .push       (push)
   );

   // The queue decouples the two sides: room depends only on its registered
   // fill level, so no combinational path runs from rsp_tready to req_tready.
   b128sc_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.run_last, head.byte_valid};
   assign rsp_tlast = head.message_end;

endmodule

`default_nettype wire

### tb/tb_base128_septet_codec_unit.sv
// ----------------------------------------------------------------------------
// tb_base128_septet_codec_unit
// Self-checking bench for the septet codec. A short table of directed requests
// covers the field extremes, both directions and the corner cases of the
// packing. Randomized messages follow, with random gaps on the request side
// and random stalls on the response side. Every response is compared with a
// cycle-free model of the repacker that runs inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_base128_septet_codec_unit;

   // Run control.
   localparam int unsigned WATCHDOG_LIMIT = 400;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned PHASE_COUNT    = 10;
   localparam int unsigned PHASE_REQUESTS = 190;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned ACC_MASK       = 32'h7fff;

   // Register map: the direction register sits at word 0. Word 1 is not
   // mapped, so writes there must leave the codec alone.
   localparam logic [2:0] ADDR_DIRECTION = {b128sc_pkg::REG_DIRECTION, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

   // Register data bytes that select each direction.
   localparam logic [7:0] ENCODE_BYTE = {7'd0, b128sc_pkg::DIR_ENCODE};
   localparam logic [7:0] DECODE_BYTE = {7'd0, b128sc_pkg::DIR_DECODE};

   // Result shorthands for the directed table, fields from the top down:
   // run_last, message_end, byte_valid, out_byte.
   localparam b128sc_pkg::result_type RES_NONE   = '0;
   localparam b128sc_pkg::result_type RES_80_MID = '{1'b0, 1'b0, 1'b1, 8'h80};
   localparam b128sc_pkg::result_type RES_80_END = '{1'b1, 1'b1, 1'b1, 8'h80};
   localparam b128sc_pkg::result_type RES_FF_MID = '{1'b0, 1'b0, 1'b1, 8'hff};
   localparam b128sc_pkg::result_type RES_FF_RUN = '{1'b1, 1'b0, 1'b1, 8'hff};
   localparam b128sc_pkg::result_type RES_FF_END = '{1'b1, 1'b1, 1'b1, 8'hff};
   localparam b128sc_pkg::result_type RES_C0_END = '{1'b1, 1'b1, 1'b1, 8'hc0};
   localparam b128sc_pkg::result_type RES_MARKER = '{1'b1, 1'b1, 1'b0, 8'h00};

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // One row of the directed table. A request row with typed set carries its
   // expected results; any other request row is checked against the model.
   // A register row writes data to addr.
   typedef struct packed {
      row_kind_type           kind;
      logic [2:0]             addr;
      logic [7:0]             data;
      logic                   last;
      logic                   typed;
      logic [1:0]             n_exp;
      b128sc_pkg::result_type exp0;
      b128sc_pkg::result_type exp1;
   } stim_row_type;

   localparam int NUM_DIRECTED = 31;
   localparam stim_row_type DIRECTED [NUM_DIRECTED] = '{
      // Encoding from reset. A single zero byte ends with a padded septet.
      '{ROW_REQ, ADDR_DIRECTION, 8'h00, 1'b1, 1'b1, 2'd2, RES_80_MID, RES_80_END},
      // All ones: the leftover low bit is padded into 0xc0.
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b1, 1'b1, 2'd2, RES_FF_MID, RES_C0_END},
      // A full group of seven 0xff bytes; the seventh gives two septets.
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b0, 1'b1, 2'd2, RES_FF_MID, RES_FF_RUN},
      // The group closed cleanly, so the next byte starts a fresh group.
      '{ROW_REQ, ADDR_DIRECTION, 8'h00, 1'b1, 1'b1, 2'd2, RES_80_MID, RES_80_END},
      '{ROW_REQ, ADDR_DIRECTION, 8'ha5, 1'b0, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h01, 1'b1, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      // An open message across a write to the unmapped word carries on.
      '{ROW_REQ, ADDR_DIRECTION, 8'h12, 1'b0, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      '{ROW_CSR, ADDR_UNMAPPED,  8'h01, 1'b0, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h80, 1'b0, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      // Switching direction aborts that message.
      '{ROW_CSR, ADDR_DIRECTION, DECODE_BYTE, 1'b0, 1'b0, 2'd0, RES_NONE, RES_NONE},
      // A one-septet message completes no byte: bare end marker.
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b1, 1'b1, 2'd1, RES_MARKER, RES_NONE},
      // Bit 7 of a septet is ignored.
      '{ROW_REQ, ADDR_DIRECTION, 8'hff, 1'b1, 1'b1, 2'd1, RES_MARKER, RES_NONE},
      // Eight all-ones septets give seven 0xff bytes; the first gives none.
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd0, RES_NONE,   RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b0, 1'b1, 2'd1, RES_FF_RUN, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h7f, 1'b1, 1'b1, 2'd1, RES_FF_END, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h80, 1'b0, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'h2a, 1'b1, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hd5, 1'b0, 1'b0, 2'd0, RES_NONE,   RES_NONE},
      // Back to encoding, which drops the open decode message.
      '{ROW_CSR, ADDR_DIRECTION, ENCODE_BYTE, 1'b0, 1'b0, 2'd0, RES_NONE, RES_NONE},
      '{ROW_REQ, ADDR_DIRECTION, 8'hc3, 1'b1, 1'b0, 2'd0, RES_NONE,   RES_NONE}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   base128_septet_codec_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] data_in
      .req_tlast   (req_tlast),   // message_end_in
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] out_byte
      .rsp_tuser   (rsp_tuser),   // [0] byte_valid, [1] run_last
      .rsp_tlast   (rsp_tlast),   // message_end
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model state of the repacker, advanced once per accepted request.
   logic                         mdl_dir;
   logic [b128sc_pkg::ACC_W-1:0] mdl_acc;
   logic [b128sc_pkg::POS_W-1:0] mdl_pos;

   // Results the codec still owes us, oldest first.
   b128sc_pkg::result_type pending_results [$];

   int unsigned err_count;
   int unsigned idle_cycles;
   int unsigned gap_max;
   int unsigned stall_max;
   int unsigned stall_left;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Counts a failure and describes the first few of them.
   function automatic void note_error(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) begin
         $display("%0t ns: %s", $time, msg);
      end
   endfunction

   // Works out the results of one request from the model state and advances
   // that state. Returns how many results the request causes (0 to 2).
   function automatic int repack_predict(input logic [7:0] d, input logic l,
                                         output b128sc_pkg::result_type [1:0] res);
      int unsigned p;
      int unsigned a;
      int unsigned have;
      int          n;
      res = '0;
      n   = 0;
      if (mdl_dir == b128sc_pkg::DIR_ENCODE) begin
         p = 32'(mdl_pos);
         a = 32'(mdl_acc);
         if (p > b128sc_pkg::ENC_LAST_POS) begin
            p = 0;
            a = 0;
         end
         // The p bits left over from earlier bytes sit above the new byte;
         // the top seven of those p + 8 bits leave as one septet.
         a = ((a << 8) | 32'(d)) & ACC_MASK;
         res[n].out_byte   = 8'(((a >> (p + 1)) & b128sc_pkg::SEPT_MASK)
                                | b128sc_pkg::SEPT_FLAG);
         res[n].byte_valid = 1'b1;
         n++;
         a &= (1 << (p + 1)) - 1;
         if (p == b128sc_pkg::ENC_LAST_POS) begin
            // Seventh byte of a group: exactly seven bits remain.
            res[n].out_byte   = 8'((a & b128sc_pkg::SEPT_MASK) | b128sc_pkg::SEPT_FLAG);
            res[n].byte_valid = 1'b1;
            n++;
            a = 0;
            p = 0;
         end else begin
            p++;
         end
         if (l && p != 0) begin
            // Flush the leftover bits, padded with zeros on the low side.
            res[n].out_byte   = 8'(((a << (7 - p)) & b128sc_pkg::SEPT_MASK)
                                   | b128sc_pkg::SEPT_FLAG);
            res[n].byte_valid = 1'b1;
            n++;
         end
      end else begin
         p    = 32'(mdl_pos);
         have = (8 - p) & 7;
         a    = ((32'(mdl_acc) << 7) | 32'(d & b128sc_pkg::SEPT_MASK)) & ACC_MASK;
         if (have != 0) begin
            res[n].out_byte   = 8'(a >> (have - 1));
            res[n].byte_valid = 1'b1;
            n++;
            a &= (1 << (have - 1)) - 1;
         end
         p = (p + 1) & 7;
         if (l && n == 0) begin
            // Nothing decoded on the last septet: a bare end marker.
            n++;
         end
      end
      mdl_acc = a[b128sc_pkg::ACC_W-1:0];
      mdl_pos = p[b128sc_pkg::POS_W-1:0];
      if (l) begin
         mdl_acc = '0;
         mdl_pos = '0;
         res[n-1].message_end = 1'b1;
      end
      if (n > 0) begin
         res[n-1].run_last = 1'b1;
      end
      return n;
   endfunction

   // Presents one request after a random gap and returns at the edge where
   // it is accepted, with req_tvalid still high so that back-to-back requests
   // need no second assignment in one step.
   task automatic send_request(input logic [7:0] d, input logic l);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Sends one request and queues what the model predicts for it.
   task automatic send_predicted(input logic [7:0] d, input logic l);
      b128sc_pkg::result_type [1:0] res;
      int                           n;
      send_request(d, l);
      n = repack_predict(d, l, res);
      for (int i = 0; i < n; i++) begin
         pending_results.push_back(res[i]);
      end
   endtask

   // Stops the request stream and waits until the codec has nothing left in
   // flight. A request can cause no result at all, so the task also waits out a
   // settle time to cover the pipeline after the last response.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes a register, then reads the direction register back. A write to
   // the direction register resets the packing state in the model as well.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_DIRECTION) begin
         mdl_dir = value[0];
         mdl_acc = '0;
         mdl_pos = '0;
      end
      // Read-back: setup cycle, then the access cycle returns the data.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_DIRECTION;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      if (got !== {31'd0, mdl_dir}) begin
         note_error($sformatf("direction read-back: expected %08h, got %08h",
                              {31'd0, mdl_dir}, got));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: random stalls between results, and a field-by-field
   // comparison of every accepted result against the oldest expectation.
   always @(posedge clock) begin
      b128sc_pkg::result_type want;
      int unsigned            stall_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, stall_max);
      end else if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_error($sformatf("unexpected result: byte %02h valid %b end %b run_last %b",
                                 rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tuser[0] !== want.byte_valid ||
                rsp_tlast !== want.message_end || rsp_tuser[1] !== want.run_last) begin
               note_error($sformatf({"result mismatch: expected byte %02h valid %b end %b ",
                                     "run_last %b, got byte %02h valid %b end %b run_last %b"},
                                    want.out_byte, want.byte_valid, want.message_end,
                                    want.run_last, rsp_tdata, rsp_tuser[0], rsp_tlast,
                                    rsp_tuser[1]));
            end
         end
         stall_next = $urandom_range(0, stall_max);
         if (stall_next == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= stall_next - 1;
         end
      end else if (!rsp_tready) begin
         if (stall_left == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   // Watchdog: any handshake or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int unsigned  sent;
      int unsigned  msg_len;
      bit           noisy;
      logic         l;
      stim_row_type row;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      mdl_dir     = b128sc_pkg::DIR_ENCODE;
      mdl_acc     = '0;
      mdl_pos     = '0;
      err_count   = 0;
      idle_cycles = 0;
      gap_max     = 10;
      stall_max   = 10;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows with typed results queue those results; the
      // model still runs on them so its state stays in step with the codec.
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED[r];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            csr_write(row.addr, {24'd0, row.data});
         end else if (row.typed) begin
            b128sc_pkg::result_type [1:0] dummy;
            send_request(row.data, row.last);
            void'(repack_predict(row.data, row.last, dummy));
            if (row.n_exp > 0) pending_results.push_back(row.exp0);
            if (row.n_exp > 1) pending_results.push_back(row.exp1);
         end else begin
            send_predicted(row.data, row.last);
         end
      end

      // Random phases. Each one picks a direction (alternating so both get
      // equal time), its own idling pressure, and then streams messages of
      // random length. A few messages carry random end flags instead, and a
      // phase may stop in the middle of a message, which the next direction
      // write then aborts.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_idle();
         if ($urandom_range(0, 3) == 0) begin
            csr_write(ADDR_UNMAPPED, $urandom());
         end
         csr_write(ADDR_DIRECTION, ($urandom() & ~32'd1) | ph[0]);
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 10;
         endcase
         case ($urandom_range(0, 2))
            0: stall_max = 0;
            1: stall_max = 3;
            default: stall_max = 10;
         endcase
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                                   : $urandom_range(1, 16);
            noisy   = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < msg_len; i++) begin
               l = noisy ? 1'($urandom_range(0, 1)) : (i == msg_len - 1);
               send_predicted(8'($urandom_range(0, 255)), l);
               sent++;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         note_error($sformatf("%0d expected results never arrived",
                              pending_results.size()));
      end
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/b128sc_pkg.sv
rtl/core/b128sc_csr.sv
rtl/core/b128sc_engine.sv
rtl/core/b128sc_out_queue.sv
rtl/core/base128_septet_codec_unit.sv
tb/tb_base128_septet_codec_unit.sv
